/* hw/rtl/ecs_pkg.sv */
// Shared types, field widths, register indexes and reset values for the
// encoder clutch sequencer. No dependencies.
`timescale 1ns / 1ps

package ecs_pkg;

    // Default structural parameters
    localparam int POSITION_BITS_DEF = 24;
    localparam int PERIOD_BITS_DEF   = 24;

    // Fixed field widths
    localparam int THR_BITS       = 24;
    localparam int PERIOD_IN_BITS = 24;
    localparam int SCALE_BITS     = 24;
    localparam int POS_OUT_BITS   = 24;
    localparam int SPEED_BITS     = 25;
    localparam int CLUTCH_COUNT   = 4;
    localparam int CFG_IDX_BITS   = 3;
    localparam int S_TDATA_BITS   = 32;
    localparam int M_TDATA_BITS   = 56;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ARM         = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RELEASE     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STAGE_TWO   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_PERIOD = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_SCALE = 3'd4;

    // Register reset values
    localparam logic [THR_BITS-1:0]       ARM_RESET        = THR_BITS'(-361);
    localparam logic [THR_BITS-1:0]       RELEASE_RESET    = THR_BITS'(-334);
    localparam logic [THR_BITS-1:0]       STAGE_TWO_RESET  = THR_BITS'(147);
    localparam logic [PERIOD_IN_BITS-1:0] STOP_PERIOD_RESET = PERIOD_IN_BITS'(36000);
    localparam logic [SCALE_BITS-1:0]     SPEED_SCALE_RESET = SCALE_BITS'(180000);

    // Clutch bit positions in the clutch vector
    localparam int CL_ONE   = 0;
    localparam int CL_TWO   = 1;
    localparam int CL_THREE = 2;
    localparam int CL_FOUR  = 3;

    // Strobes from the top-level sequencer to the count/clutch unit
    typedef struct packed {
        logic step;         // edge accepted: move the count, latch slowness
        logic eval;         // run threshold checks and clutch sequencing
        logic forward;      // direction of the accepted edge
        logic period_over;  // accepted period exceeds the stop period
    } seq_ctrl_t;

    // Count thresholds
    typedef struct packed {
        logic [THR_BITS-1:0] arm_thr;
        logic [THR_BITS-1:0] rel_thr;
        logic [THR_BITS-1:0] st2_thr;
    } thr_cfg_t;

endpackage

/* hw/rtl/ecs_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on ecs_pkg.
`timescale 1ns / 1ps

module ecs_divider #(
    parameter int DIVISOR_BITS = ecs_pkg::PERIOD_IN_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ecs_pkg::SCALE_BITS-1:0]    dividend,
    input  logic [DIVISOR_BITS-1:0]           divisor,
    output logic                              done,
    output logic [ecs_pkg::SCALE_BITS-1:0]    quotient
);
    import ecs_pkg::*;

    localparam int CNT_W = $clog2(SCALE_BITS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SCALE_BITS - 1);

    logic                    busy_reg, busy_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0] dsr_reg, dsr_next;
    logic [SCALE_BITS-1:0]   quo_reg, quo_next;

    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS+1:0] diff;
    logic                    ge;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    // A zero divisor always succeeds, which leaves an all-ones quotient.
    assign trial = {rem_reg, quo_reg[SCALE_BITS-1]};
    assign diff  = {1'b0, trial} - {2'b00, dsr_reg};
    assign ge    = !diff[DIVISOR_BITS+1];

    assign done     = busy_reg && (cnt_reg == LAST_STEP);
    assign quotient = quo_reg;

    // Advance one quotient bit per cycle
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            quo_next = {quo_reg[SCALE_BITS-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    // A new request never lands on a running division
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

/* hw/rtl/ecs_sequencer.sv */
// Step count, slowness flag and clutch sequencing state for each edge.
// Depends on ecs_pkg.
`timescale 1ns / 1ps

module ecs_sequencer #(
    parameter int POSITION_BITS = ecs_pkg::POSITION_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ecs_pkg::seq_ctrl_t                 ctrl,
    input  ecs_pkg::thr_cfg_t                  thr,
    output logic                               first_seen,
    output logic [ecs_pkg::POS_OUT_BITS-1:0]   position,
    output logic [ecs_pkg::CLUTCH_COUNT-1:0]   clutch
);
    import ecs_pkg::*;

    localparam int CW = ((POSITION_BITS > THR_BITS) ? POSITION_BITS : THR_BITS) + 1;
    localparam logic signed [POSITION_BITS-1:0] POS_MAX = {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN = {1'b1, {(POSITION_BITS-1){1'b0}}};

    logic signed [POSITION_BITS-1:0] count_reg, count_next;
    logic                            first_seen_reg, first_seen_next;
    logic                            slow_reg, slow_next;
    logic                            armed_reg, armed_next;
    logic                            finished_reg, finished_next;
    logic [CLUTCH_COUNT-1:0]         clutch_reg, clutch_next;

    logic signed [CW-1:0] cnt_ext;
    logic                 below_arm, above_rel, above_st2;
    logic                 armed_v;

    // Signed threshold compares on the stored count
    assign cnt_ext   = CW'(count_reg);
    assign below_arm = cnt_ext < CW'($signed(thr.arm_thr));
    assign above_rel = cnt_ext > CW'($signed(thr.rel_thr));
    assign above_st2 = cnt_ext > CW'($signed(thr.st2_thr));
    assign armed_v   = armed_reg || below_arm;

    // Move the count on an accepted edge; the first edge only marks itself
    always_comb begin
        count_next      = count_reg;
        first_seen_next = first_seen_reg;
        slow_next       = slow_reg;
        if (ctrl.step) begin
            first_seen_next = 1'b1;
            slow_next       = !first_seen_reg || !ctrl.forward || ctrl.period_over;
            if (first_seen_reg) begin
                if (ctrl.forward) begin
                    if (count_reg != POS_MAX) begin
                        count_next = count_reg + POSITION_BITS'(1);
                    end
                end else if (count_reg != POS_MIN) begin
                    count_next = count_reg - POSITION_BITS'(1);
                end
            end
        end
    end

    // Step the clutches through release, stage two and stop
    always_comb begin
        armed_next    = armed_reg;
        finished_next = finished_reg;
        clutch_next   = clutch_reg;
        if (ctrl.eval) begin
            armed_next = armed_v;
            if (above_rel && armed_v) begin
                clutch_next[CL_TWO] = 1'b0;
                clutch_next[CL_ONE] = 1'b1;
                if (above_st2) begin
                    clutch_next[CL_FOUR]  = 1'b0;
                    clutch_next[CL_THREE] = 1'b1;
                    if (slow_reg) begin
                        clutch_next[CL_THREE] = 1'b0;
                        clutch_next[CL_FOUR]  = 1'b1;
                        clutch_next[CL_TWO]   = 1'b1;
                        clutch_next[CL_ONE]   = 1'b1;
                        armed_next            = 1'b0;
                        finished_next         = 1'b1;
                    end
                end
            end else if (!finished_reg) begin
                clutch_next[CL_ONE] = 1'b0;
                clutch_next[CL_TWO] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            first_seen_reg <= 1'b0;
            slow_reg       <= 1'b0;
            armed_reg      <= 1'b0;
            finished_reg   <= 1'b0;
            clutch_reg     <= '0;
        end else begin
            count_reg      <= count_next;
            first_seen_reg <= first_seen_next;
            slow_reg       <= slow_next;
            armed_reg      <= armed_next;
            finished_reg   <= finished_next;
            clutch_reg     <= clutch_next;
        end
    end

    assign first_seen = first_seen_reg;
    assign position   = cnt_ext[POS_OUT_BITS-1:0];
    assign clutch     = clutch_reg;

    // The count moves only on an accepted edge
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(ctrl.step) |-> $stable(count_reg))
        else $error("step count moved without an edge");

    // Once the stop step has run, the sequence stays finished
    a_finished_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(finished_reg) |-> finished_reg)
        else $error("finished flag cleared");

    // Clutches change only on an evaluation
    a_clutch_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(ctrl.eval) |-> $stable(clutch_reg))
        else $error("clutch levels changed outside evaluation");

endmodule

/* hw/rtl/encoder_clutch_sequencer_core.sv */
// Top level of the encoder clutch sequencer: stream ports, configuration
// registers, control sequencing and output register. Depends on ecs_pkg,
// ecs_divider and ecs_sequencer.
// Sequence for an ordinary edge: accept, the 24-step bit-serial speed divider,
// one evaluation, then one load that waits while the output is stalled; the
// first edge after reset skips the divider.
// A new edge is accepted only in the idle state, once the last result is loaded.
// Reset: synchronous active-low aresetn clears count, flags and clutches
// and reloads every configuration register with its default.
`timescale 1ns / 1ps

module encoder_clutch_sequencer_core #(
    parameter int POSITION_BITS = ecs_pkg::POSITION_BITS_DEF,
    parameter int PERIOD_BITS   = ecs_pkg::PERIOD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input edges
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] phase_b, [24:1] edge_period_us, [31:25] zero
    input  logic [ecs_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // Results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [23:0] position_count, [48:24] speed_dps, [49] clutch_one,
    // [50] clutch_two, [51] clutch_three, [52] clutch_four, [55:53] zero
    output logic [ecs_pkg::M_TDATA_BITS-1:0]   m_tdata,
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ecs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ecs_pkg::THR_BITS-1:0]       cfg_data
);
    import ecs_pkg::*;

    localparam int PW = (PERIOD_BITS < PERIOD_IN_BITS) ? PERIOD_BITS : PERIOD_IN_BITS;
    localparam logic [PERIOD_IN_BITS-1:0] PERIOD_MAX =
        PERIOD_IN_BITS'((64'd1 << PW) - 64'd1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    // Configuration registers
    logic [THR_BITS-1:0]       arm_reg, rel_reg, st2_reg;
    logic [PERIOD_IN_BITS-1:0] stop_reg;
    logic [SCALE_BITS-1:0]     scale_reg;

    // Per-edge context
    logic dir_reg, dir_next;
    logic zero_speed_reg, zero_speed_next;

    // Output register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    logic                      s_accept, cfg_accept, out_free;
    logic [PERIOD_IN_BITS-1:0] period_in, period_clamp;
    logic                      div_start, div_done;
    logic [SCALE_BITS-1:0]     div_quo, speed_mag;
    logic [SPEED_BITS-1:0]     speed;
    seq_ctrl_t                 ctrl;
    thr_cfg_t                  thr;
    logic                      first_seen;
    logic [POS_OUT_BITS-1:0]   position;
    logic [CLUTCH_COUNT-1:0]   clutch;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !m_tvalid_reg || m_tready;

    // Clamp the period to the supported range
    assign period_in    = s_tdata[PERIOD_IN_BITS:1];
    assign period_clamp = (period_in > PERIOD_MAX) ? PERIOD_MAX : period_in;

    // Configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_reg   <= ARM_RESET;
            rel_reg   <= RELEASE_RESET;
            st2_reg   <= STAGE_TWO_RESET;
            stop_reg  <= STOP_PERIOD_RESET;
            scale_reg <= SPEED_SCALE_RESET;
        end else if (cfg_accept) begin
            unique case (cfg_index)
                CFG_ARM:         arm_reg   <= cfg_data;
                CFG_RELEASE:     rel_reg   <= cfg_data;
                CFG_STAGE_TWO:   st2_reg   <= cfg_data;
                CFG_STOP_PERIOD: stop_reg  <= cfg_data;
                CFG_SPEED_SCALE: scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign thr.arm_thr = arm_reg;
    assign thr.rel_thr = rel_reg;
    assign thr.st2_thr = st2_reg;

    // Strobes to the count/clutch unit and the divider
    assign ctrl.step        = s_accept;
    assign ctrl.eval        = (state_reg == ST_EVAL);
    assign ctrl.forward     = s_tdata[0];
    assign ctrl.period_over = period_clamp > stop_reg;
    assign div_start        = s_accept && first_seen;

    ecs_divider #(
        .DIVISOR_BITS(PW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (scale_reg),
        .divisor  (period_clamp[PW-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    ecs_sequencer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .thr        (thr),
        .first_seen (first_seen),
        .position   (position),
        .clutch     (clutch)
    );

    // Signed speed; the divider already yields all ones for a zero period
    assign speed_mag = zero_speed_reg ? '0 : div_quo;
    assign speed     = dir_reg ? {1'b0, speed_mag} : -{1'b0, speed_mag};

    // Control sequence: accept, divide (skipped for the first edge), evaluate, load the result
    always_comb begin
        state_next      = state_reg;
        dir_next        = dir_reg;
        zero_speed_next = zero_speed_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    dir_next        = s_tdata[0];
                    zero_speed_next = !first_seen;
                    state_next      = first_seen ? ST_DIV : ST_EVAL;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000, clutch, speed, position};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        dir_reg        <= dir_next;
        zero_speed_reg <= zero_speed_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A result appears only from the load step
    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the load step");

    // An accepted edge always moves on to division or evaluation
    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_DIV || state_reg == ST_EVAL))
        else $error("accepted edge left the control sequence");

    // The divider finishes only while the control sequence waits for it
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

endmodule

/* dv/encoder_clutch_sequencer_core_tb.sv */
// Self-checking testbench for encoder_clutch_sequencer_core: encoder edges in,
// count/speed/clutch results checked against an in-bench predictor.
// Depends on ecs_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module encoder_clutch_sequencer_core_tb;
    import ecs_pkg::*;

    localparam longint POS_MAX    = (longint'(1) << (POSITION_BITS_DEF - 1)) - 1;
    localparam longint POS_MIN    = -POS_MAX - 1;
    localparam longint PERIOD_MAX = (longint'(1) << PERIOD_IN_BITS) - 1;
    localparam longint SPEED_SAT  = 16777215;
    localparam int     PHASE_ITEMS = 250;

    typedef struct packed {
        logic [POS_OUT_BITS-1:0] position;
        logic [SPEED_BITS-1:0]   speed;
        logic [CLUTCH_COUNT-1:0] clutches;
    } edge_outcome_t;

    // Predicts count, speed and clutch levels per edge and checks results in order
    class clutch_scoreboard;
        longint arm_thr, rel_thr, st2_thr, stop_period, speed_scale;
        longint step_count;
        bit     first_seen, armed, finished;
        logic [CLUTCH_COUNT-1:0] clutches;
        edge_outcome_t predicted_results[$];
        int errors;

        function new();
            arm_thr     = longint'(signed'(ARM_RESET));
            rel_thr     = longint'(signed'(RELEASE_RESET));
            st2_thr     = longint'(signed'(STAGE_TWO_RESET));
            stop_period = longint'(STOP_PERIOD_RESET);
            speed_scale = longint'(SPEED_SCALE_RESET);
            step_count  = 0;
            first_seen  = 0;
            armed       = 0;
            finished    = 0;
            clutches    = '0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [THR_BITS-1:0] value);
            case (idx)
                CFG_ARM:         arm_thr     = longint'(signed'(value));
                CFG_RELEASE:     rel_thr     = longint'(signed'(value));
                CFG_STAGE_TWO:   st2_thr     = longint'(signed'(value));
                CFG_STOP_PERIOD: stop_period = longint'(value);
                CFG_SPEED_SCALE: speed_scale = longint'(value);
                default: ;
            endcase
        endfunction

        function void note_edge(bit fwd, logic [PERIOD_IN_BITS-1:0] period);
            longint        per;
            longint        mag;
            longint        speed;
            bit            slow;
            edge_outcome_t r;
            per   = longint'(period);
            speed = 0;
            // first edge only marks itself: the count stays and the speed is zero
            if (!first_seen) begin
                first_seen = 1;
                slow = 1;
            end else begin
                mag = (per == 0) ? SPEED_SAT : speed_scale / per;
                if (mag > SPEED_SAT) mag = SPEED_SAT;
                speed = fwd ? mag : -mag;
                if (fwd) begin
                    if (step_count < POS_MAX) step_count++;
                    slow = per > stop_period;
                end else begin
                    if (step_count > POS_MIN) step_count--;
                    slow = 1;
                end
            end
            // arm, release, stage two, stop
            if (step_count < arm_thr) armed = 1;
            if (step_count > rel_thr && armed) begin
                clutches[CL_TWO] = 1'b0;
                clutches[CL_ONE] = 1'b1;
                if (step_count > st2_thr) begin
                    clutches[CL_FOUR]  = 1'b0;
                    clutches[CL_THREE] = 1'b1;
                    if (slow) begin
                        clutches[CL_THREE] = 1'b0;
                        clutches[CL_FOUR]  = 1'b1;
                        clutches[CL_TWO]   = 1'b1;
                        clutches[CL_ONE]   = 1'b1;
                        armed    = 0;
                        finished = 1;
                    end
                end
            end else if (!finished) begin
                clutches[CL_ONE] = 1'b0;
                clutches[CL_TWO] = 1'b1;
            end
            r.position = step_count[POS_OUT_BITS-1:0];
            r.speed    = speed[SPEED_BITS-1:0];
            r.clutches = clutches;
            predicted_results.push_back(r);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%t %s", $realtime, msg);
        endfunction

        function void compare_field(string name, longint exp_v, longint act_v);
            if (exp_v != act_v)
                flag($sformatf("mismatch %s: expected %0h, got %0h", name, exp_v, act_v));
        endfunction

        function void check_result(logic [M_TDATA_BITS-1:0] d);
            edge_outcome_t e;
            if (predicted_results.size() == 0) begin
                flag($sformatf("unexpected result %0h", d));
                return;
            end
            e = predicted_results.pop_front();
            compare_field("position_count", longint'(e.position), longint'(d[23:0]));
            compare_field("speed_dps", longint'(e.speed), longint'(d[48:24]));
            compare_field("clutch_one", longint'(e.clutches[CL_ONE]), longint'(d[49]));
            compare_field("clutch_two", longint'(e.clutches[CL_TWO]), longint'(d[50]));
            compare_field("clutch_three", longint'(e.clutches[CL_THREE]),
                          longint'(d[51]));
            compare_field("clutch_four", longint'(e.clutches[CL_FOUR]), longint'(d[52]));
        endfunction

        function int pending();
            return predicted_results.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    // [0] phase_b, [24:1] edge_period_us, [31:25] zero
    logic [S_TDATA_BITS-1:0]   s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    // [23:0] position_count, [48:24] speed_dps, [52:49] clutch one..four
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index;
    logic [THR_BITS-1:0]       cfg_data;

    clutch_scoreboard sb;
    bit sender_idle;
    bit receiver_idle;
    bit hold_request;
    int edges_sent;

    encoder_clutch_sequencer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(50, 8);
    endfunction

    function automatic logic [PERIOD_IN_BITS-1:0] rand_period();
        longint p;
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return PERIOD_IN_BITS'($urandom_range(16, 1));
            3: begin
                // around the stop period boundary
                p = sb.stop_period + longint'($urandom_range(2)) - 1;
                if (p < 0) p = 0;
                if (p > PERIOD_MAX) p = PERIOD_MAX;
                return PERIOD_IN_BITS'(p);
            end
            4: return PERIOD_IN_BITS'($urandom_range(4096, 1));
            default: return PERIOD_IN_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [PERIOD_IN_BITS-1:0] fast_period();
        if (sb.stop_period == 0) return '0;
        case ($urandom_range(3))
            0: return '0;
            1: return PERIOD_IN_BITS'(sb.stop_period);
            default: return PERIOD_IN_BITS'($urandom_range(32'(sb.stop_period), 0));
        endcase
    endfunction

    function automatic logic [PERIOD_IN_BITS-1:0] slow_period();
        if (sb.stop_period >= PERIOD_MAX) return '1;
        case ($urandom_range(2))
            0: return PERIOD_IN_BITS'(sb.stop_period + 1);
            1: return '1;
            default: return PERIOD_IN_BITS'($urandom_range(32'(PERIOD_MAX),
                                                          32'(sb.stop_period + 1)));
        endcase
    endfunction

    // Offer one edge and hold it until accepted; valid stays up for back-to-back edges
    task automatic send_edge(input bit fwd, input logic [PERIOD_IN_BITS-1:0] period);
        int g;
        g = pick_gap(sender_idle);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, period, fwd};
        do @(posedge aclk); while (!s_tready);
        sb.note_edge(fwd, period);
        edges_sent++;
    endtask

    // Drop valid and let every outstanding result drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_regs(input longint arm, input longint rel, input longint st2,
                              input longint stop, input longint scale);
        logic [CFG_IDX_BITS-1:0] idx [5];
        logic [THR_BITS-1:0]     val [5];
        idx[0] = CFG_ARM;         val[0] = THR_BITS'(arm);
        idx[1] = CFG_RELEASE;     val[1] = THR_BITS'(rel);
        idx[2] = CFG_STAGE_TWO;   val[2] = THR_BITS'(st2);
        idx[3] = CFG_STOP_PERIOD; val[3] = THR_BITS'(stop);
        idx[4] = CFG_SPEED_SCALE; val[4] = THR_BITS'(scale);
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // One full swing: arm below the arm threshold, climb fast past stage two,
    // then usually end with a slow edge
    task automatic run_swing();
        int n;
        bit back_slow;
        n = 0;
        while (sb.step_count >= sb.arm_thr && n < 300) begin
            send_edge(1'b0, rand_period());
            n++;
        end
        back_slow = (sb.stop_period >= PERIOD_MAX) || ($urandom_range(2) == 0);
        n = 0;
        while (sb.step_count <= sb.st2_thr + back_slow && n < 300) begin
            send_edge(1'b1, fast_period());
            n++;
        end
        if ($urandom_range(9) != 0) begin
            if (back_slow) send_edge(1'b0, rand_period());
            else send_edge(1'b1, slow_period());
        end
    endtask

    // Result side: random stalls, plus one long hold on request
    initial begin
        int g;
        m_tready = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            g = hold_request ? 400 : pick_gap(receiver_idle);
            hold_request = 0;
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Reset, directed edges, then randomized phases under several settings
    initial begin
        longint arm;
        int     start;
        sb = new();
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        sender_idle   = 0;
        receiver_idle = 0;
        hold_request  = 0;
        edges_sent    = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: first edge, zero and longest periods, stop boundary
        send_edge(1'b1, 24'h123456);
        send_edge(1'b1, '0);
        send_edge(1'b0, '0);
        send_edge(1'b1, '1);
        send_edge(1'b1, 24'd1);
        send_edge(1'b1, STOP_PERIOD_RESET);
        send_edge(1'b1, PERIOD_IN_BITS'(STOP_PERIOD_RESET + 1));
        send_edge(1'b0, 24'h555555);
        send_edge(1'b1, 24'hAAAAAA);
        send_edge(1'b0, 24'd7);

        // tight thresholds: walk the whole arm/release/stage-two/stop sequence
        drain();
        write_regs(-3, -1, 2, 1000, SPEED_SAT);
        run_swing();

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            sender_idle   = (ph % 3 != 2);
            receiver_idle = (ph % 4 != 3);
            case (ph)
                0: begin
                    // hold the result side while edges keep coming
                    sender_idle  = 0;
                    hold_request = 1;
                end
                1: write_regs(POS_MAX, POS_MIN, POS_MIN, PERIOD_MAX, 1);
                2: write_regs(POS_MIN, POS_MAX, POS_MAX, 0, 0);
                default: begin
                    arm = -longint'($urandom_range(40, 1));
                    write_regs(arm, arm + $urandom_range(20, 0),
                               arm + $urandom_range(50, 0),
                               ($urandom_range(3) == 0) ? 0 :
                               ($urandom_range(1) ? $urandom_range(5000, 1) :
                                                    longint'($urandom() & 32'hFFFFFF)),
                               ($urandom_range(3) == 0) ? SPEED_SAT :
                               longint'($urandom_range(200000, 1)));
                end
            endcase
            start = edges_sent;
            while (edges_sent - start < PHASE_ITEMS) begin
                if (ph != 2 && $urandom_range(9) < 7) begin
                    run_swing();
                end else begin
                    repeat ($urandom_range(5, 1))
                        send_edge(1'($urandom_range(1)), rand_period());
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ecs_pkg.sv
hw/rtl/ecs_divider.sv
hw/rtl/ecs_sequencer.sv
hw/rtl/encoder_clutch_sequencer_core.sv
dv/encoder_clutch_sequencer_core_tb.sv
